// ----- rtl/core/bpcs_pkg.sv -----
`default_nettype none

package bpcs_pkg;

  // Field widths of the ports.
  localparam int unsigned PixW    = 8;
  localparam int unsigned StrideW = 13;
  localparam int unsigned SpeedW  = 12;
  localparam int unsigned TurnW   = 16;

  // Configuration port.
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 13;

  localparam logic [CfgIdxW-1:0] RegRowStride   = 2'd0;
  localparam logic [CfgIdxW-1:0] RegBrightLevel = 2'd1;
  localparam logic [CfgIdxW-1:0] RegFwdSpeed    = 2'd2;

  localparam logic [StrideW-1:0] RowStrideRst   = 13'd2400;
  localparam logic [PixW-1:0]    BrightLevelRst = 8'd255;
  localparam logic [SpeedW-1:0]  FwdSpeedRst    = 12'd410;

  // Frame limits.
  localparam logic [StrideW-1:0] MaxStride     = 13'd4096;
  localparam int unsigned        ColW          = 12;
  localparam int unsigned        CntW          = 23;
  localparam logic [CntW-1:0]    MaxFrameBytes = 23'd4194304;

  // Signed offset sum and the divisor (match count times stride).
  localparam int unsigned SumW = 36;
  localparam int unsigned DenW = CntW + StrideW;

  // The turn magnitude is |sum| * 2^14 / divisor, saturated at 2^14.
  localparam int unsigned QuoW  = 14;
  localparam int unsigned StepW = $clog2(QuoW);
  localparam logic [StepW-1:0] LastStep = StepW'(QuoW - 1);
  localparam logic [QuoW:0]    TurnLimit = 15'd16384;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;    // an input byte transfers this cycle
    logic snap;      // the transferred byte ends the frame
    logic mul;       // form divisor and magnitude
    logic chk;       // saturation check, load the remainder
    logic step;      // one restoring division step
    logic load_out;  // load the result register
  } bpcs_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic saturate;  // quotient would reach the turn limit
  } bpcs_status_t;

endpackage

`default_nettype wire

// ----- rtl/core/bpcs_ctrl.sv -----
`default_nettype none

module bpcs_ctrl (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  input  wire logic                    in_end_of_frame,
  output logic                         in_stall,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output bpcs_pkg::bpcs_cmd_t          cmd,
  input  wire bpcs_pkg::bpcs_status_t  status
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_CHK  = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;

  logic [2:0]                 state_r, state_nxt;
  logic [bpcs_pkg::StepW-1:0] step_r, step_nxt;
  logic                       busy;

  // Bytes keep flowing during the division; only a second frame end waits.
  always_comb begin
    busy      = (state_r != ST_IDLE);
    in_stall  = busy & in_valid & in_end_of_frame;
    out_valid = (state_r == ST_OUT);

    cmd.accept   = in_valid & ~in_stall;
    cmd.snap     = in_valid & ~in_stall & in_end_of_frame;
    cmd.mul      = (state_r == ST_MUL);
    cmd.chk      = (state_r == ST_CHK);
    cmd.step     = (state_r == ST_DIV);
    cmd.load_out = (state_r == ST_FIN);
  end

  // Next state and division step count.
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd.snap) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        state_nxt = ST_CHK;
      end
      ST_CHK: begin
        step_nxt  = '0;
        state_nxt = status.saturate ? ST_FIN : ST_DIV;
      end
      ST_DIV: begin
        step_nxt = step_r + 1'b1;
        if (step_r == bpcs_pkg::LastStep) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  // A frame end is never taken while the previous one is still in work.
  a_no_snap_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.snap |-> !busy)
    else $error("frame end taken while busy");

  // The division step count never runs past the last step.
  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (step_r <= bpcs_pkg::LastStep))
    else $error("division step count out of range");

  // A frame end always leads to the multiply state.
  a_snap_mul: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.snap |=> (state_r == ST_MUL))
    else $error("frame end did not start the result sequence");

endmodule

`default_nettype wire

// ----- rtl/core/bpcs_datapath.sv -----
`default_nettype none

module bpcs_datapath (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [bpcs_pkg::CfgIdxW-1:0]   cfg_index,
  input  wire logic [bpcs_pkg::CfgDataW-1:0]  cfg_data,
  input  wire logic [bpcs_pkg::PixW-1:0]      in_pixel,
  input  wire bpcs_pkg::bpcs_cmd_t            cmd,
  output bpcs_pkg::bpcs_status_t              status,
  output logic                                out_target_found,
  output logic [bpcs_pkg::SpeedW-1:0]         out_linear_speed,
  output logic signed [bpcs_pkg::TurnW-1:0]   out_angular_rate,
  output logic                                out_frame_overflow
);

  // Configuration registers.
  logic [bpcs_pkg::StrideW-1:0] row_stride_r;
  logic [bpcs_pkg::PixW-1:0]    bright_level_r;
  logic [bpcs_pkg::SpeedW-1:0]  fwd_speed_r;

  // Frame accumulators.
  logic [bpcs_pkg::ColW-1:0]        col_r, col_nxt;
  logic signed [bpcs_pkg::SumW-1:0] sum_r, sum_nxt;
  logic [bpcs_pkg::CntW-1:0]        mcnt_r, mcnt_nxt;
  logic [bpcs_pkg::CntW-1:0]        bcnt_r, bcnt_nxt;
  logic                             ovf_r, ovf_nxt;

  // Snapshot of a finished frame.
  logic signed [bpcs_pkg::SumW-1:0] s_sum_r;
  logic [bpcs_pkg::CntW-1:0]        s_cnt_r;
  logic [bpcs_pkg::StrideW-1:0]     s_stride_r;
  logic [bpcs_pkg::SpeedW-1:0]      s_speed_r;
  logic                             s_ovf_r;

  // Divider.
  logic [bpcs_pkg::DenW-1:0] d_r;
  logic [bpcs_pkg::SumW-1:0] mag_r;
  logic                      neg_r;
  logic                      sat_r;
  logic [bpcs_pkg::SumW-1:0] rem_r;
  logic [bpcs_pkg::QuoW-1:0] q_r;

  logic [bpcs_pkg::StrideW-1:0] stride;
  logic [bpcs_pkg::ColW-1:0]    col_use;
  logic [bpcs_pkg::StrideW-1:0] col_inc;
  logic signed [14:0]           offset;
  logic                         full;
  logic [bpcs_pkg::SumW:0]      rem_sh;
  logic [bpcs_pkg::SumW:0]      rem_diff;
  logic                         rem_ge;
  logic [bpcs_pkg::QuoW:0]      turn_mag;
  logic [bpcs_pkg::TurnW-1:0]   turn_abs;

  // Register writes; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_stride_r   <= bpcs_pkg::RowStrideRst;
      bright_level_r <= bpcs_pkg::BrightLevelRst;
      fwd_speed_r    <= bpcs_pkg::FwdSpeedRst;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bpcs_pkg::RegRowStride:   row_stride_r   <= cfg_data;
        bpcs_pkg::RegBrightLevel: bright_level_r <= cfg_data[bpcs_pkg::PixW-1:0];
        bpcs_pkg::RegFwdSpeed:    fwd_speed_r    <= cfg_data[bpcs_pkg::SpeedW-1:0];
        default: ;
      endcase
    end
  end

  // Stride clamped into 1..MaxStride.
  always_comb begin
    priority if (row_stride_r == '0) begin
      stride = bpcs_pkg::StrideW'(1);
    end else if (row_stride_r > bpcs_pkg::MaxStride) begin
      stride = bpcs_pkg::MaxStride;
    end else begin
      stride = row_stride_r;
    end
  end

  // Per-byte accumulation; a column past a shrunk stride restarts at zero.
  always_comb begin
    full    = (bcnt_r >= bpcs_pkg::MaxFrameBytes);
    col_use = ({1'b0, col_r} >= stride) ? '0 : col_r;
    col_inc = {1'b0, col_use} + bpcs_pkg::StrideW'(1);
    offset  = $signed({2'b00, col_use, 1'b0}) - $signed({2'b00, stride});

    col_nxt  = col_r;
    sum_nxt  = sum_r;
    mcnt_nxt = mcnt_r;
    bcnt_nxt = bcnt_r;
    ovf_nxt  = ovf_r;
    if (cmd.accept) begin
      if (full) begin
        ovf_nxt = 1'b1;
      end else begin
        if (in_pixel == bright_level_r) begin
          sum_nxt  = sum_r + {{(bpcs_pkg::SumW-15){offset[14]}}, offset};
          mcnt_nxt = mcnt_r + 1'b1;
        end
        col_nxt  = (col_inc >= stride) ? '0 : col_inc[bpcs_pkg::ColW-1:0];
        bcnt_nxt = bcnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      sum_r  <= '0;
      mcnt_r <= '0;
      bcnt_r <= '0;
      ovf_r  <= 1'b0;
    end else if (cmd.snap) begin
      col_r  <= '0;
      sum_r  <= '0;
      mcnt_r <= '0;
      bcnt_r <= '0;
      ovf_r  <= 1'b0;
    end else begin
      col_r  <= col_nxt;
      sum_r  <= sum_nxt;
      mcnt_r <= mcnt_nxt;
      bcnt_r <= bcnt_nxt;
      ovf_r  <= ovf_nxt;
    end
  end

  // Snapshot of the closing frame, including its last byte.
  always_ff @(posedge clk) begin
    if (cmd.snap) begin
      s_sum_r    <= sum_nxt;
      s_cnt_r    <= mcnt_nxt;
      s_stride_r <= stride;
      s_speed_r  <= fwd_speed_r;
      s_ovf_r    <= ovf_nxt;
    end
  end

  // Restoring division step on the remainder.
  always_comb begin
    rem_sh   = {rem_r, 1'b0};
    rem_ge   = (rem_sh >= {1'b0, d_r});
    rem_diff = rem_sh - {1'b0, d_r};
    status.saturate = (mag_r >= d_r);
  end

  // Divisor, magnitude, saturation check and division steps.
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      d_r   <= s_cnt_r * s_stride_r;
      mag_r <= s_sum_r[bpcs_pkg::SumW-1] ? bpcs_pkg::SumW'(-s_sum_r)
                                         : bpcs_pkg::SumW'(s_sum_r);
      neg_r <= (s_sum_r > 0);
    end
    if (cmd.chk) begin
      sat_r <= status.saturate;
      rem_r <= mag_r;
      q_r   <= '0;
    end else if (cmd.step) begin
      rem_r <= rem_ge ? rem_diff[bpcs_pkg::SumW-1:0] : rem_r << 1;
      q_r   <= {q_r[bpcs_pkg::QuoW-2:0], rem_ge};
    end
  end

  // Result register; turn takes the opposite sign of the offset sum.
  always_comb begin
    turn_mag = sat_r ? bpcs_pkg::TurnLimit : {1'b0, q_r};
    turn_abs = {1'b0, turn_mag};
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_frame_overflow <= s_ovf_r;
      if (s_cnt_r != '0) begin
        out_target_found <= 1'b1;
        out_linear_speed <= s_speed_r;
        out_angular_rate <= neg_r ? $signed(-turn_abs) : $signed(turn_abs);
      end else begin
        out_target_found <= 1'b0;
        out_linear_speed <= '0;
        out_angular_rate <= '0;
      end
    end
  end

  // The remainder stays below the divisor through every step.
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> (rem_r < d_r))
    else $error("division remainder not below divisor");

  // The byte counter never runs past the frame limit.
  a_bcnt_limit: assert property (@(posedge clk) disable iff (!rst_n)
    bcnt_r <= bpcs_pkg::MaxFrameBytes)
    else $error("byte counter beyond frame limit");

  // A frame without a target gives zero speed and turn.
  a_no_target_zero: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> (out_target_found
                      || (out_linear_speed == '0 && out_angular_rate == '0)))
    else $error("nonzero command without a target");

endmodule

`default_nettype wire

// ----- rtl/core/bright_pixel_centroid_steering.sv -----
`default_nettype none

// Channel   Ports                                       Transfer
// in        in_valid, in_stall, in_pixel, in_end_of_frame   valid & !stall
// out       out_valid, out_stall, out_target_found,        valid & !stall
//           out_linear_speed, out_angular_rate, out_frame_overflow
// cfg       cfg_we, cfg_index, cfg_data                 cfg_we
//
// One input byte is taken every cycle while in_stall is low; accumulation is
// a single adder stage. A frame end starts the result sequence: multiply,
// saturation check, up to 14 restoring division steps and a result load.
// Bytes of the next frame are taken meanwhile.
// A further frame end is stalled until the pending result has transferred.
// Synchronous reset loads the register defaults and clears the accumulators.

module bright_pixel_centroid_steering (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [bpcs_pkg::CfgIdxW-1:0]   cfg_index,
  input  wire logic [bpcs_pkg::CfgDataW-1:0]  cfg_data,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [bpcs_pkg::PixW-1:0]      in_pixel,
  input  wire logic                           in_end_of_frame,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic                                out_target_found,
  output logic [bpcs_pkg::SpeedW-1:0]         out_linear_speed,
  output logic signed [bpcs_pkg::TurnW-1:0]   out_angular_rate,
  output logic                                out_frame_overflow
);

  bpcs_pkg::bpcs_cmd_t    cmd;
  bpcs_pkg::bpcs_status_t status;

  // Sequencer for the handshakes and the division.
  bpcs_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_end_of_frame (in_end_of_frame),
    .in_stall        (in_stall),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .cmd             (cmd),
    .status          (status)
  );

  // Accumulators, divider and result register.
  bpcs_datapath u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_pixel           (in_pixel),
    .cmd                (cmd),
    .status             (status),
    .out_target_found   (out_target_found),
    .out_linear_speed   (out_linear_speed),
    .out_angular_rate   (out_angular_rate),
    .out_frame_overflow (out_frame_overflow)
  );

endmodule

`default_nettype wire

// ----- sim/bright_pixel_centroid_steering_tb.sv -----
`timescale 1ns / 100ps

module bright_pixel_centroid_steering_tb;
  import bpcs_pkg::*;

  // Index that maps to no register; writes to it must change nothing.
  localparam logic [CfgIdxW-1:0] RegSpare = 2'd3;
  localparam int unsigned StuckLimit   = 1000;
  localparam int unsigned TargetItems  = 1850;
  localparam int unsigned SettleCycles = 25;

  // One steering command as it leaves the block.
  typedef struct {
    logic                     found;
    logic [SpeedW-1:0]        speed;
    logic signed [TurnW-1:0]  turn;
    logic                     ovf;
  } steer_cmd_t;

  // Tracks the register file and frame accumulators, and queues the commands
  // that frame ends will produce.
  class steer_tracker;
    logic [StrideW-1:0] stride_reg;
    logic [PixW-1:0]    bright_reg;
    logic [SpeedW-1:0]  speed_reg;
    int unsigned        column;
    longint             offset_sum;
    int unsigned        match_count;
    int unsigned        byte_count;
    bit                 overflow_seen;
    steer_cmd_t         steer_cmds[$];
    int unsigned        mismatches;

    function new();
      stride_reg  = RowStrideRst;
      bright_reg  = BrightLevelRst;
      speed_reg   = FwdSpeedRst;
      mismatches  = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      column        = 0;
      offset_sum    = 0;
      match_count   = 0;
      byte_count    = 0;
      overflow_seen = 1'b0;
    endfunction

    // Register writes keep only the bits the register holds.
    function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        RegRowStride: begin
          stride_reg = data[StrideW-1:0];
        end
        RegBrightLevel: begin
          bright_reg = data[PixW-1:0];
        end
        RegFwdSpeed: begin
          speed_reg = data[SpeedW-1:0];
        end
        default: begin
        end
      endcase
    endfunction

    // Accumulate one transferred byte; on a frame end, queue the command.
    function void take_pixel(logic [PixW-1:0] pix, logic eof);
      int unsigned stride;
      int unsigned col;
      longint      quo;
      longint      lim;
      steer_cmd_t  cmd;
      if (stride_reg == 0) stride = 1;
      else if (stride_reg > MaxStride) stride = MaxStride;
      else stride = stride_reg;

      if (byte_count >= MaxFrameBytes) begin
        overflow_seen = 1'b1;
      end else begin
        // A column left over from a wider stride restarts at zero.
        col = (column >= stride) ? 0 : column;
        if (pix == bright_reg) begin
          offset_sum += 2 * longint'(col) - longint'(stride);
          match_count++;
        end
        col++;
        column = (col >= stride) ? 0 : col;
        byte_count++;
      end

      if (eof) begin
        cmd.found = 1'b0;
        cmd.speed = '0;
        cmd.turn  = '0;
        cmd.ovf   = overflow_seen;
        if (match_count != 0) begin
          lim = longint'(TurnLimit);
          quo = (-offset_sum * 16384) / (longint'(match_count) * longint'(stride));
          if (quo > lim) quo = lim;
          else if (quo < -lim) quo = -lim;
          cmd.found = 1'b1;
          cmd.speed = speed_reg;
          cmd.turn  = quo[TurnW-1:0];
        end
        steer_cmds.push_back(cmd);
        clear_frame();
      end
    endfunction

    // Compare a transferred command with the oldest one queued.
    function void compare_command(logic found, logic [SpeedW-1:0] speed,
                                  logic signed [TurnW-1:0] turn, logic ovf);
      steer_cmd_t want;
      if (steer_cmds.size() == 0) begin
        $display("%0t: command with no frame end pending: found %0b speed %0d turn %0d ovf %0b",
                 $time, found, speed, turn, ovf);
        mismatches++;
        return;
      end
      want = steer_cmds.pop_front();
      if (found !== want.found) begin
        $display("%0t: target_found expected %0b, got %0b", $time, want.found, found);
        mismatches++;
      end
      if (speed !== want.speed) begin
        $display("%0t: linear_speed expected %0d, got %0d", $time, want.speed, speed);
        mismatches++;
      end
      if (turn !== want.turn) begin
        $display("%0t: angular_rate expected %0d, got %0d", $time, want.turn, turn);
        mismatches++;
      end
      if (ovf !== want.ovf) begin
        $display("%0t: frame_overflow expected %0b, got %0b", $time, want.ovf, ovf);
        mismatches++;
      end
    endfunction
  endclass

  logic                     clk;
  logic                     rst_n;
  logic                     cfg_we;
  logic [CfgIdxW-1:0]       cfg_index;
  logic [CfgDataW-1:0]      cfg_data;
  logic                     in_valid;
  logic                     in_stall;
  logic [PixW-1:0]          in_pixel;
  logic                     in_end_of_frame;
  logic                     out_valid;
  logic                     out_stall;
  logic                     out_target_found;
  logic [SpeedW-1:0]        out_linear_speed;
  logic signed [TurnW-1:0]  out_angular_rate;
  logic                     out_frame_overflow;

  steer_tracker tracker;
  bit           quiet;
  int unsigned  sent_items;
  int unsigned  stuck_cycles;

  bright_pixel_centroid_steering i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_pixel           (in_pixel),
    .in_end_of_frame    (in_end_of_frame),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_target_found   (out_target_found),
    .out_linear_speed   (out_linear_speed),
    .out_angular_rate   (out_angular_rate),
    .out_frame_overflow (out_frame_overflow)
  );

  // 10 ns clock.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    if ($urandom_range(15) == 0) return $urandom_range(10, 60);
    return $urandom_range(1, 3);
  endfunction

  // Stride values weighted toward small strides and the edges of the range.
  function automatic logic [CfgDataW-1:0] rand_stride();
    case ($urandom_range(9))
      0: return '0;
      1: return 13'd1;
      2: return MaxStride;
      3: return 13'h1FFF;
      4: return CfgDataW'($urandom_range(4097, 8190));
      5: return CfgDataW'($urandom_range(13, 4095));
      default: return CfgDataW'($urandom_range(2, 12));
    endcase
  endfunction

  // Watch both channels at the rising edge and feed every transfer to the tracker.
  always @(posedge clk) begin : transfer_monitor
    bit moved;
    moved = 1'b0;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        tracker.take_pixel(in_pixel, in_end_of_frame);
        moved = 1'b1;
      end
      if (out_valid && !out_stall) begin
        tracker.compare_command(out_target_found, out_linear_speed, out_angular_rate,
                                out_frame_overflow);
        moved = 1'b1;
      end
      if (moved) stuck_cycles = 0;
      else stuck_cycles++;
      if (stuck_cycles >= StuckLimit) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // Result side: random stall stretches, none in quiet phases.
  initial begin : result_sink
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (!quiet && $urandom_range(3) == 0) begin
        out_stall <= 1'b1;
        repeat (pick_gap()) @(negedge clk);
      end
      out_stall <= 1'b0;
    end
  end

  // Present one byte and hold it until the transfer. Called at a falling edge.
  task automatic send_byte(input logic [PixW-1:0] pix, input logic eof);
    int unsigned gap;
    gap = (!quiet && $urandom_range(2) == 0) ? pick_gap() : 0;
    if (gap != 0) begin
      // Idle bus carries junk that the block must ignore.
      in_valid        <= 1'b0;
      in_pixel        <= PixW'($urandom);
      in_end_of_frame <= 1'($urandom);
      repeat (gap) @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_pixel        <= pix;
    in_end_of_frame <= eof;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    sent_items++;
  endtask

  // Stop sending and wait until every queued command has come out.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (tracker.steer_cmds.size() != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    tracker.set_reg(idx, data);
    @(negedge clk);
  endtask

  // A frame of random bytes, many of them at the bright level; optionally the
  // stride changes partway through while the block is idle.
  task automatic send_frame(input int unsigned len, input bit restride);
    int unsigned    cut;
    logic [PixW-1:0] pix;
    cut = restride ? $urandom_range(1, len - 1) : 0;
    for (int unsigned i = 0; i < len; i++) begin
      if (restride && i == cut) begin
        drain_results();
        write_reg(RegRowStride, rand_stride());
      end
      pix = ($urandom_range(9) < 4) ? tracker.bright_reg : PixW'($urandom);
      send_byte(pix, i == len - 1);
    end
  endtask

  initial begin : stimulus
    logic [PixW-1:0]   level;
    logic [SpeedW-1:0] spd;
    int unsigned       nframes;
    int unsigned       len;

    tracker         = new();
    quiet           = 1'b0;
    sent_items      = 0;
    stuck_cycles    = 0;
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    in_valid        = 1'b0;
    in_pixel        = '0;
    in_end_of_frame = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset registers: a frame with no target, then one with two bright bytes.
    send_byte(8'd0, 1'b1);
    send_byte(8'd255, 1'b0);
    send_byte(8'd0, 1'b0);
    send_byte(8'd255, 1'b1);
    drain_results();

    // Zero stride acts as one; stray upper data bits are dropped; the spare
    // index changes nothing.
    write_reg(RegRowStride, '0);
    write_reg(RegBrightLevel, 13'h1F00);
    write_reg(RegFwdSpeed, 13'h1FFF);
    write_reg(RegSpare, 13'h0005);
    send_byte(8'd0, 1'b0);
    send_byte(8'd17, 1'b1);
    drain_results();

    // Oversize stride clamps to the maximum; zero forward speed.
    write_reg(RegRowStride, 13'h1FFF);
    write_reg(RegFwdSpeed, '0);
    send_byte(8'd255, 1'b0);
    send_byte(8'd0, 1'b1);
    drain_results();

    // Stride shrinks within a frame: the turn saturates positive.
    write_reg(RegRowStride, 13'd8);
    write_reg(RegBrightLevel, 13'd200);
    write_reg(RegFwdSpeed, 13'd1234);
    send_byte(8'd200, 1'b0);
    repeat (5) send_byte(8'd1, 1'b0);
    drain_results();
    write_reg(RegRowStride, 13'd1);
    send_byte(8'd3, 1'b1);
    drain_results();

    // Same again with a match right of center: the turn saturates negative.
    write_reg(RegRowStride, 13'd8);
    repeat (7) send_byte(8'd9, 1'b0);
    send_byte(8'd200, 1'b0);
    drain_results();
    write_reg(RegRowStride, 13'd2);
    send_byte(8'd0, 1'b1);
    drain_results();

    // Random phases: fresh registers, a burst of frames, then a full drain.
    while (sent_items < TargetItems) begin
      quiet = ($urandom_range(3) == 0);
      write_reg(RegRowStride, rand_stride());
      case ($urandom_range(3))
        0: level = '0;
        1: level = '1;
        default: level = PixW'($urandom);
      endcase
      write_reg(RegBrightLevel, {5'($urandom), level});
      case ($urandom_range(3))
        0: spd = '0;
        1: spd = '1;
        default: spd = SpeedW'($urandom);
      endcase
      write_reg(RegFwdSpeed, {1'($urandom), spd});
      if ($urandom_range(3) == 0) write_reg(RegSpare, CfgDataW'($urandom));
      nframes = $urandom_range(4, 10);
      repeat (nframes) begin
        len = ($urandom_range(7) == 0) ? $urandom_range(25, 400) : $urandom_range(1, 24);
        send_frame(len, len > 1 && $urandom_range(7) == 0);
      end
      drain_results();
    end

    if (tracker.mismatches == 0 && tracker.steer_cmds.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
